### rtl/color_key_centroid_tracker_top_defines.svh
// Assertion macros used by the tracker RTL (included by the controller).
`ifndef COLOR_KEY_CENTROID_TRACKER_TOP_DEFINES_SVH
`define COLOR_KEY_CENTROID_TRACKER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define CKCT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ckct: implication check failed");

// Next-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define CKCT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ckct: next-cycle check failed");

`endif

### rtl/ckct_pkg.sv
// Package: constants, register indexes and control structs of the tracker.
package ckct_pkg;

  localparam int MAX_COLS    = 1024;
  localparam int MAX_ROWS    = 1024;
  localparam int MIN_MATCHES = 50;
  localparam int DEAD_BAND   = 30;

  localparam int PIX_W   = 8;
  localparam int SIZE_W  = 11;
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int MATCH_W = COL_W + ROW_W + 1;
  localparam int CSUM_W  = COL_W + COL_W + ROW_W;
  localparam int RSUM_W  = ROW_W + COL_W + ROW_W;
  localparam int SUM_W   = (CSUM_W > RSUM_W) ? CSUM_W : RSUM_W;
  localparam int QUOT_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = SIZE_W;

  localparam logic [PIX_W-1:0]  PIX_WHITE   = 8'd255;
  localparam logic [PIX_W-1:0]  TOL_RESET   = 8'd15;
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd480;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_B  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_G  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_R  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd6;

  localparam logic signed [1:0] TURN_NONE = 2'sb00;
  localparam logic signed [1:0] TURN_POS  = 2'sb01;
  localparam logic signed [1:0] TURN_NEG  = 2'sb11;

  localparam logic RESULT_PIXEL   = 1'b0;
  localparam logic RESULT_SUMMARY = 1'b1;

  typedef struct packed {
    logic pix_accept;
    logic div_start;
    logic sum_load;
  } ckct_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic div_busy;
  } ckct_sts_t;

endpackage

### rtl/color_key_centroid_tracker_top.sv
// Top level of the colour-key centroid tracker: controller plus datapath.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+------------------------------------
//  pixel   | in        | in_valid_i / in_ready_o     | pix_blue_i, pix_green_i, pix_red_i
//  config  | in        | cfg_valid_i / cfg_ready_o   | cfg_index_i, cfg_data_i
//  result  | out       | out_valid_o / out_ready_i   | result_kind_o .. last_of_run_o
//
// Outside the frame-end sequence, a pixel transfer is taken every cycle while the output
// register is free or being drained, so a stream runs at one pixel per clock.
// On the last pixel of a frame, no pixel is taken while the controller starts the divider,
// runs the bit-per-cycle dual-lane divider steps, sees it finish and registers the
// summary.
// A stalled result holds the pixel channel; config is always ready.
// Reset (asynchronous, active low) clears config to defaults and all counters at once.
module color_key_centroid_tracker_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ckct_pkg::PIX_W-1:0]      pix_blue_i,
  input  logic [ckct_pkg::PIX_W-1:0]      pix_green_i,
  input  logic [ckct_pkg::PIX_W-1:0]      pix_red_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ckct_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ckct_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            result_kind_o,
  output logic [ckct_pkg::PIX_W-1:0]      out_blue_o,
  output logic [ckct_pkg::PIX_W-1:0]      out_green_o,
  output logic [ckct_pkg::PIX_W-1:0]      out_red_o,
  output logic                            object_found_o,
  output logic [ckct_pkg::COL_W-1:0]      centroid_col_o,
  output logic [ckct_pkg::ROW_W-1:0]      centroid_row_o,
  output logic signed [1:0]               turn_command_o,
  output logic                            last_of_run_o
);
  import ckct_pkg::*;

  ckct_cmd_t cmd;
  ckct_sts_t sts;

  // The user is to write config only while idle; the block does not enforce this and has no interlock
  assign cfg_ready_o = 1'b1;

  // Sequencing: pixel transfers, frame-end divide, summary load
  ckct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Matching, sums, centroid divide, turn latch, result register
  ckct_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_write_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .pix_blue_i     (pix_blue_i),
    .pix_green_i    (pix_green_i),
    .pix_red_i      (pix_red_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_kind_o  (result_kind_o),
    .out_blue_o     (out_blue_o),
    .out_green_o    (out_green_o),
    .out_red_o      (out_red_o),
    .object_found_o (object_found_o),
    .centroid_col_o (centroid_col_o),
    .centroid_row_o (centroid_row_o),
    .turn_command_o (turn_command_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

### rtl/ckct_div.sv
// Dual-lane restoring divider, one quotient bit per lane per cycle, shared divisor.
module ckct_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ckct_pkg::MATCH_W-1:0]  divisor_i,
  input  logic [ckct_pkg::SUM_W-1:0]    dividend_a_i,
  input  logic [ckct_pkg::SUM_W-1:0]    dividend_b_i,
  output logic [ckct_pkg::QUOT_W-1:0]   quot_a_o,
  output logic [ckct_pkg::QUOT_W-1:0]   quot_b_o,
  output logic                          busy_o
);
  import ckct_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [MATCH_W-1:0] div_q;
  logic [MATCH_W-1:0] rem_a_q, rem_a_d, rem_b_q, rem_b_d;
  logic [QUOT_W-1:0]  num_a_q, num_a_d, num_b_q, num_b_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               qa, qb;

  // One restoring step: returns {quotient bit, new remainder}
  function automatic logic [MATCH_W:0] div_step(input logic [MATCH_W-1:0] rem,
                                                input logic             nbit,
                                                input logic [MATCH_W-1:0] dvs);
    logic [MATCH_W:0] trial;
    logic [MATCH_W:0] diff;
    trial = {rem, nbit};
    diff  = trial - {1'b0, dvs};
    if (trial >= {1'b0, dvs}) begin
      div_step = {1'b1, diff[MATCH_W-1:0]};
    end else begin
      div_step = {1'b0, trial[MATCH_W-1:0]};
    end
  endfunction

  always_comb begin
    {qa, rem_a_d} = div_step(rem_a_q, num_a_q[QUOT_W-1], div_q);
    {qb, rem_b_d} = div_step(rem_b_q, num_b_q[QUOT_W-1], div_q);
    num_a_d = {num_a_q[QUOT_W-2:0], qa};
    num_b_d = {num_b_q[QUOT_W-2:0], qb};
    cnt_d   = cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(QUOT_W);
    end else if (busy_o) begin
      cnt_q <= cnt_d;
    end
  end

  // Quotient fits QUOT_W bits, so the upper dividend bits seed the remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q   <= divisor_i;
      rem_a_q <= MATCH_W'(dividend_a_i >> QUOT_W);
      rem_b_q <= MATCH_W'(dividend_b_i >> QUOT_W);
      num_a_q <= dividend_a_i[QUOT_W-1:0];
      num_b_q <= dividend_b_i[QUOT_W-1:0];
    end else if (busy_o) begin
      rem_a_q <= rem_a_d;
      rem_b_q <= rem_b_d;
      num_a_q <= num_a_d;
      num_b_q <= num_b_d;
    end
  end

  assign busy_o   = (cnt_q != '0);
  assign quot_a_o = num_a_q;
  assign quot_b_o = num_b_q;

endmodule

### rtl/ckct_ctrl.sv
// Controller: handshakes, output-register occupancy and frame-end sequencing.
`include "color_key_centroid_tracker_top_defines.svh"
module ckct_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  ckct_pkg::ckct_sts_t sts_i,
  output ckct_pkg::ckct_cmd_t cmd_o
);
  import ckct_pkg::*;

  typedef enum logic [1:0] {
    S_RUN,
    S_START,
    S_DIV,
    S_SUM
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  always_comb begin
    out_free         = !out_valid_q || out_ready_i;
    in_ready_o       = (state_q == S_RUN) && out_free;
    cmd_o.pix_accept = in_valid_i && in_ready_o;
    cmd_o.div_start  = (state_q == S_START);
    cmd_o.sum_load   = (state_q == S_SUM) && out_free;

    state_d = state_q;
    unique case (state_q)
      S_RUN:   if (cmd_o.pix_accept && sts_i.frame_end) state_d = S_START;
      S_START: state_d = S_DIV;
      S_DIV:   if (!sts_i.div_busy) state_d = S_SUM;
      S_SUM:   if (out_free) state_d = S_RUN;
      default: state_d = S_RUN;
    endcase

    if (cmd_o.pix_accept || cmd_o.sum_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `CKCT_ASSERT_NXT(a_frame_end_starts_div, cmd_o.pix_accept && sts_i.frame_end, state_q == S_START)
  `CKCT_ASSERT_NXT(a_div_runs, state_q == S_START, sts_i.div_busy)
  `CKCT_ASSERT_NXT(a_result_held, out_valid_q && !out_ready_i, out_valid_q)
  `CKCT_ASSERT_IMP(a_no_accept_in_summary, state_q != S_RUN, !cmd_o.pix_accept)

endmodule

### rtl/ckct_dp.sv
// Datapath: config registers, matching, accumulators, centroid, turn and output register.
module ckct_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_write_i,
  input  logic [ckct_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ckct_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  input  logic [ckct_pkg::PIX_W-1:0]      pix_blue_i,
  input  logic [ckct_pkg::PIX_W-1:0]      pix_green_i,
  input  logic [ckct_pkg::PIX_W-1:0]      pix_red_i,
  input  ckct_pkg::ckct_cmd_t             cmd_i,
  output ckct_pkg::ckct_sts_t             sts_o,
  output logic                            result_kind_o,
  output logic [ckct_pkg::PIX_W-1:0]      out_blue_o,
  output logic [ckct_pkg::PIX_W-1:0]      out_green_o,
  output logic [ckct_pkg::PIX_W-1:0]      out_red_o,
  output logic                            object_found_o,
  output logic [ckct_pkg::COL_W-1:0]      centroid_col_o,
  output logic [ckct_pkg::ROW_W-1:0]      centroid_row_o,
  output logic signed [1:0]               turn_command_o,
  output logic                            last_of_run_o
);
  import ckct_pkg::*;

  logic              en_q;
  logic [PIX_W-1:0]  key_b_q, key_g_q, key_r_q, tol_q;
  logic [SIZE_W-1:0] width_q, height_q;

  logic [COL_W-1:0]   col_q;
  logic [ROW_W-1:0]   row_q;
  logic [MATCH_W-1:0] cnt_q;
  logic [SUM_W-1:0]   csum_q, rsum_q;
  logic               found_q;
  logic signed [1:0]  turn_q, turn_d;

  logic [SIZE_W-1:0]  w_eff, h_eff;
  logic               row_end, frame_end, match;
  logic [QUOT_W-1:0]  quot_c, quot_r;
  logic               div_busy;
  logic signed [QUOT_W+1:0] diff;

  function automatic logic in_window(input logic [PIX_W-1:0] p,
                                     input logic [PIX_W-1:0] k,
                                     input logic [PIX_W-1:0] t);
    logic [PIX_W:0] pt;
    logic [PIX_W:0] kt;
    pt = {1'b0, p} + {1'b0, t};
    kt = {1'b0, k} + {1'b0, t};
    in_window = (pt > {1'b0, k}) && ({1'b0, p} < kt);
  endfunction

  // Config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b0;
      key_b_q  <= '0;
      key_g_q  <= '0;
      key_r_q  <= '0;
      tol_q    <= TOL_RESET;
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_write_i) begin
      unique case (cfg_index_i)
        CFG_ENABLE: en_q     <= cfg_data_i[0];
        CFG_KEY_B:  key_b_q  <= cfg_data_i[PIX_W-1:0];
        CFG_KEY_G:  key_g_q  <= cfg_data_i[PIX_W-1:0];
        CFG_KEY_R:  key_r_q  <= cfg_data_i[PIX_W-1:0];
        CFG_TOL:    tol_q    <= cfg_data_i[PIX_W-1:0];
        CFG_WIDTH:  width_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < SIZE_W'(2))             w_eff = SIZE_W'(2);
    else if (width_q > SIZE_W'(MAX_COLS)) w_eff = SIZE_W'(MAX_COLS);
    else                                  w_eff = width_q;
    if (height_q < SIZE_W'(1))             h_eff = SIZE_W'(1);
    else if (height_q > SIZE_W'(MAX_ROWS)) h_eff = SIZE_W'(MAX_ROWS);
    else                                   h_eff = height_q;

    row_end   = SIZE_W'(col_q) >= (w_eff - SIZE_W'(1));
    frame_end = row_end && (SIZE_W'(row_q) >= (h_eff - SIZE_W'(1)));
    match     = en_q && in_window(pix_blue_i, key_b_q, tol_q)
                     && in_window(pix_green_i, key_g_q, tol_q)
                     && in_window(pix_red_i, key_r_q, tol_q);

    diff = $signed({2'b00, quot_c}) - $signed((QUOT_W+2)'(w_eff >> 1));
    turn_d = turn_q;
    if (diff > (QUOT_W+2)'(DEAD_BAND) || diff < -(QUOT_W+2)'(DEAD_BAND)) begin
      if (turn_q == TURN_NONE) turn_d = (diff > 0) ? TURN_NEG : TURN_POS;
    end else begin
      turn_d = TURN_NONE;
    end
  end

  assign sts_o.frame_end = frame_end;
  assign sts_o.div_busy  = div_busy;

  // Raster position and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      cnt_q   <= '0;
      csum_q  <= '0;
      rsum_q  <= '0;
      found_q <= 1'b0;
      turn_q  <= TURN_NONE;
    end else begin
      if (cmd_i.pix_accept) begin
        if (frame_end) begin
          col_q <= '0;
          row_q <= '0;
        end else if (row_end) begin
          col_q <= '0;
          row_q <= row_q + ROW_W'(1);
        end else begin
          col_q <= col_q + COL_W'(1);
        end
        if (match) begin
          cnt_q  <= cnt_q + MATCH_W'(1);
          csum_q <= csum_q + SUM_W'(col_q);
          rsum_q <= rsum_q + SUM_W'(row_q);
        end
      end
      if (cmd_i.div_start) begin
        found_q <= en_q && (rsum_q != '0) && (csum_q != '0)
                   && (cnt_q > MATCH_W'(MIN_MATCHES));
        cnt_q   <= '0;
        csum_q  <= '0;
        rsum_q  <= '0;
      end
      if (cmd_i.sum_load && found_q) turn_q <= turn_d;
    end
  end

  ckct_div u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (cmd_i.div_start),
    .divisor_i    (cnt_q),
    .dividend_a_i (csum_q),
    .dividend_b_i (rsum_q),
    .quot_a_o     (quot_c),
    .quot_b_o     (quot_r),
    .busy_o       (div_busy)
  );

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_accept) begin
      result_kind_o  <= RESULT_PIXEL;
      out_blue_o     <= match ? PIX_WHITE : pix_blue_i;
      out_green_o    <= match ? PIX_WHITE : pix_green_i;
      out_red_o      <= match ? PIX_WHITE : pix_red_i;
      object_found_o <= 1'b0;
      centroid_col_o <= '0;
      centroid_row_o <= '0;
      turn_command_o <= TURN_NONE;
      last_of_run_o  <= !frame_end;
    end else if (cmd_i.sum_load) begin
      result_kind_o  <= RESULT_SUMMARY;
      out_blue_o     <= '0;
      out_green_o    <= '0;
      out_red_o      <= '0;
      object_found_o <= found_q;
      centroid_col_o <= found_q ? quot_c[COL_W-1:0] : '0;
      centroid_row_o <= found_q ? quot_r[ROW_W-1:0] : '0;
      turn_command_o <= found_q ? turn_d : turn_q;
      last_of_run_o  <= 1'b1;
    end
  end

endmodule
